>>> rtl/rbsi_pkg.sv
`default_nettype none
package rbsi_pkg;

  // Per-transaction side information carried alongside the dividers.
  // Lane 2*a divides the lower bound of axis a, lane 2*a+1 the upper bound.
  typedef struct packed {
    logic [5:0] neg;       // quotient sign of each lane
    logic [5:0] sat;       // quotient magnitude saturates
    logic [2:0] dir_zero;  // direction component is zero
    logic [2:0] dir_neg;   // direction component is negative
    logic [2:0] out_slab;  // origin lies outside the slab
  } rbsi_flags_t;

  localparam int unsigned NumLanes = 6;
  localparam int unsigned NumAxes  = 3;

endpackage
`default_nettype wire

>>> rtl/rbsi_prep.sv
`default_nettype none
module rbsi_prep #(
  parameter int unsigned W  = 32,
  parameter int unsigned F  = 16,
  parameter int unsigned DW = 2 * W + F
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          vld_i,
  input  wire logic [2:0][W-1:0]             org_i,
  input  wire logic [2:0][W-1:0]             dir_i,
  input  wire logic [2:0][W-1:0]             lo_i,
  input  wire logic [2:0][W-1:0]             hi_i,
  output logic                               vld_o,
  output logic [5:0][DW-1:0]                 rem_o,
  output logic [5:0][W-1:0]                  den_o,
  output rbsi_pkg::rbsi_flags_t              flg_o
);

  localparam int unsigned S = W - 1 - F;

  logic                  vld_r;
  logic [5:0][DW-1:0]    rem_r, rem_nxt;
  logic [5:0][W-1:0]     den_r, den_nxt;
  rbsi_pkg::rbsi_flags_t flg_r, flg_nxt;

  always_comb begin
    logic signed [W:0] diff;
    logic [W:0]        mag;
    logic [W-1:0]      dmag;
    logic [W-1:0]      bnd;
    flg_nxt = '0;
    rem_nxt = '0;
    den_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      dmag = dir_i[a][W-1] ? (~dir_i[a] + 1'b1) : dir_i[a];
      flg_nxt.dir_zero[a] = (dir_i[a] == '0);
      flg_nxt.dir_neg[a]  = dir_i[a][W-1];
      flg_nxt.out_slab[a] = ($signed(org_i[a]) < $signed(lo_i[a])) ||
                            ($signed(org_i[a]) > $signed(hi_i[a]));
      for (int b = 0; b < 2; b++) begin
        bnd  = (b == 0) ? lo_i[a] : hi_i[a];
        diff = $signed({bnd[W-1], bnd}) - $signed({org_i[a][W-1], org_i[a]});
        mag  = diff[W] ? (~diff + 1'b1) : diff;
        rem_nxt[2*a+b] = {{(DW-W-1){1'b0}}, mag} << F;
        den_nxt[2*a+b] = dmag;
        flg_nxt.neg[2*a+b] = diff[W] ^ dir_i[a][W-1];
        flg_nxt.sat[2*a+b] = {{(DW-W-1){1'b0}}, mag} >= ({{(DW-W){1'b0}}, dmag} << S);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    flg_r <= flg_nxt;
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign flg_o = flg_r;

endmodule
`default_nettype wire

>>> rtl/rbsi_div_cell.sv
`default_nettype none
module rbsi_div_cell #(
  parameter int unsigned W     = 32,
  parameter int unsigned DW    = 80,
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     vld_i,
  input  wire logic [5:0][DW-1:0]       rem_i,
  input  wire logic [5:0][W-1:0]        den_i,
  input  wire logic [5:0][W-2:0]        quo_i,
  input  wire rbsi_pkg::rbsi_flags_t    flg_i,
  output logic                          vld_o,
  output logic [5:0][DW-1:0]            rem_o,
  output logic [5:0][W-1:0]             den_o,
  output logic [5:0][W-2:0]             quo_o,
  output rbsi_pkg::rbsi_flags_t         flg_o
);

  logic                  vld_r;
  logic [5:0][DW-1:0]    rem_r, rem_nxt;
  logic [5:0][W-1:0]     den_r;
  logic [5:0][W-2:0]     quo_r, quo_nxt;
  rbsi_pkg::rbsi_flags_t flg_r;

  // One restoring-division step per lane: this cell decides quotient bit SHIFT.
  always_comb begin
    logic [DW-1:0] dsh;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    for (int l = 0; l < 6; l++) begin
      dsh = {{(DW-W){1'b0}}, den_i[l]} << SHIFT;
      if (rem_i[l] >= dsh) begin
        rem_nxt[l]        = rem_i[l] - dsh;
        quo_nxt[l][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_i;
    quo_r <= quo_nxt;
    flg_r <= flg_i;
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;
  assign flg_o = flg_r;

endmodule
`default_nettype wire

>>> rtl/rbsi_combine.sv
`default_nettype none
module rbsi_combine #(
  parameter int unsigned W = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   vld_i,
  input  wire logic [5:0][W-2:0]      quo_i,
  input  wire rbsi_pkg::rbsi_flags_t  flg_i,
  output logic                        vld_o,
  output logic                        hit_o,
  output logic [W-2:0]                t_near_o,
  output logic [W-2:0]                t_far_o
);

  logic         vld_r;
  logic         hit_r, hit_nxt;
  logic [W-2:0] tn_r, tn_nxt, tf_r, tf_nxt;

  // Signed slab distances, then the interval is narrowed axis by axis.
  // Near only grows and far only shrinks, so a miss at any axis persists.
  always_comb begin
    logic signed [W-1:0] tv [6];
    logic signed [W-1:0] t0, t1, near, far;
    logic [W-2:0]        qs;
    for (int l = 0; l < 6; l++) begin
      qs    = flg_i.sat[l] ? {(W-1){1'b1}} : quo_i[l];
      tv[l] = flg_i.neg[l] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    end
    near = '0;
    far  = $signed({1'b0, {(W-1){1'b1}}});
    for (int a = 0; a < 3; a++) begin
      t0 = flg_i.dir_neg[a] ? tv[2*a+1] : tv[2*a];
      t1 = flg_i.dir_neg[a] ? tv[2*a]   : tv[2*a+1];
      if (!flg_i.dir_zero[a]) begin
        if (t0 > near) near = t0;
        if (t1 < far)  far  = t1;
      end
    end
    hit_nxt = !(|(flg_i.dir_zero & flg_i.out_slab)) && (far > near);
    tn_nxt  = hit_nxt ? near[W-2:0] : '0;
    tf_nxt  = hit_nxt ? far[W-2:0]  : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    tn_r  <= tn_nxt;
    tf_r  <= tf_nxt;
  end

  assign vld_o    = vld_r;
  assign hit_o    = hit_r;
  assign t_near_o = tn_r;
  assign t_far_o  = tf_r;

endmodule
`default_nettype wire

>>> rtl/ray_box_slab_intersect.sv
// Throughput: one transaction per cycle; busy is always low.
// The pipeline is one setup stage, COORD_WIDTH-1 divider cells and one final stage.
// Reset (rst_n low, synchronous) empties the pipeline; in-flight work is dropped.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
`default_nettype none
module ray_box_slab_intersect #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_max_z,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [COORD_WIDTH-2:0]             out_t_near,
  output logic [COORD_WIDTH-2:0]             out_t_far
);

  // Width of the division remainder: wide enough for the scaled numerator
  // and for the divisor shifted to the top quotient bit.
  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned DW    = 2 * COORD_WIDTH + FRAC_BITS;
  localparam int unsigned NCELL = COORD_WIDTH - 1;

  // The pipeline never stalls, so a new transaction is welcome every cycle.
  assign busy = 1'b0;

  logic                  vld   [NCELL+1];
  logic [5:0][DW-1:0]    rem   [NCELL+1];
  logic [5:0][W-1:0]     den   [NCELL+1];
  logic [5:0][W-2:0]     quo   [NCELL+1];
  rbsi_pkg::rbsi_flags_t flg   [NCELL+1];

  // The first stage forms bound - origin at full precision, takes magnitudes,
  // and decides saturation with a single compare against the shifted divisor.
  rbsi_prep #(.W(W), .F(FRAC_BITS), .DW(DW)) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (start),
    .org_i ({in_origin_z, in_origin_y, in_origin_x}),
    .dir_i ({in_dir_z, in_dir_y, in_dir_x}),
    .lo_i  ({in_box_min_z, in_box_min_y, in_box_min_x}),
    .hi_i  ({in_box_max_z, in_box_max_y, in_box_max_x}),
    .vld_o (vld[0]),
    .rem_o (rem[0]),
    .den_o (den[0]),
    .flg_o (flg[0])
  );

  assign quo[0] = '0;

  // A row of identical division cells. Cell k resolves quotient bit
  // COORD_WIDTH-2-k for all six slab distances, then hands the partial
  // remainder to its neighbor. When the quotient saturates, the bits built
  // here are ignored by the final stage.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rbsi_div_cell #(.W(W), .DW(DW), .SHIFT(NCELL - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld[k]),
      .rem_i (rem[k]),
      .den_i (den[k]),
      .quo_i (quo[k]),
      .flg_i (flg[k]),
      .vld_o (vld[k+1]),
      .rem_o (rem[k+1]),
      .den_o (den[k+1]),
      .quo_o (quo[k+1]),
      .flg_o (flg[k+1])
    );
  end

  // The final stage applies signs, saturation and the direction swap, and
  // narrows the interval [0, T_MAX] across the three axes.
  rbsi_combine #(.W(W)) u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (vld[NCELL]),
    .quo_i    (quo[NCELL]),
    .flg_i    (flg[NCELL]),
    .vld_o    (out_valid),
    .hit_o    (out_hit),
    .t_near_o (out_t_near),
    .t_far_o  (out_t_far)
  );

endmodule
`default_nettype wire

>>> rtl/rbsi_checker.sv
`default_nettype none
module rbsi_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire logic                   out_hit,
  input wire logic [COORD_WIDTH-2:0] out_t_near,
  input wire logic [COORD_WIDTH-2:0] out_t_far
);

  localparam int unsigned Lat = COORD_WIDTH + 1;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised on a stall-free pipeline");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Lat out_valid)
    else $error("result missing after fixed latency");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_t_near == '0 && out_t_far == '0))
    else $error("miss carries nonzero distances");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_t_near < out_t_far))
    else $error("hit with empty interval");

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_hit    (out_hit),
  .out_t_near (out_t_near),
  .out_t_far  (out_t_far)
);
`default_nettype wire

>>> sim/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Defaults of the block: Q16.16 coordinates, 31-bit unsigned distances.
  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;
  localparam longint TMax = (64'sd1 <<< (CW - 1)) - 1;
  // The pipeline is COORD_WIDTH + 1 deep; the drain wait gives it some slack.
  localparam int unsigned DrainCycles = CW + 20;

  // One ray and one box, in the order origin, direction, lower and upper corner.
  typedef struct packed {
    logic signed [CW-1:0] org_x, org_y, org_z;
    logic signed [CW-1:0] dir_x, dir_y, dir_z;
    logic signed [CW-1:0] lo_x, lo_y, lo_z;
    logic signed [CW-1:0] hi_x, hi_y, hi_z;
  } ray_box_t;

  typedef struct packed {
    logic          hit;
    logic [CW-2:0] t_near;
    logic [CW-2:0] t_far;
  } hit_span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ray_box_t ray_in = '0;
  logic out_valid, out_hit;
  logic [CW-2:0] out_t_near, out_t_far;

  ray_box_t  pending_rays[$];
  hit_span_t expected_spans[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  bit        stim_done = 1'b0;

  always #10 clk = ~clk;

  ray_box_slab_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(ray_in.org_x), .in_origin_y(ray_in.org_y), .in_origin_z(ray_in.org_z),
    .in_dir_x(ray_in.dir_x), .in_dir_y(ray_in.dir_y), .in_dir_z(ray_in.dir_z),
    .in_box_min_x(ray_in.lo_x), .in_box_min_y(ray_in.lo_y), .in_box_min_z(ray_in.lo_z),
    .in_box_max_x(ray_in.hi_x), .in_box_max_y(ray_in.hi_y), .in_box_max_z(ray_in.hi_z),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_t_near(out_t_near), .out_t_far(out_t_far)
  );

  // Slab distance num * 2^FB / den, truncated toward zero, then saturated in
  // magnitude to TMax. The numerator is at most 33 bits wide, so shifting it
  // left by FB still fits comfortably in 64 bits.
  function automatic longint slab_distance(longint num, longint den);
    longint mag_n, mag_d, quo;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    quo = (mag_n <<< FB) / mag_d;
    if (quo > TMax) quo = TMax;
    return ((num < 0) != (den < 0)) ? -quo : quo;
  endfunction

  // Clips the interval [0, TMax] against the three slabs in x, y, z order.
  function automatic hit_span_t clip_ray(ray_box_t r);
    logic signed [CW-1:0] org[3], dir[3], lo[3], hi[3];
    longint near_t, far_t, t0, t1, swap;
    bit live;
    hit_span_t res;
    org = '{r.org_x, r.org_y, r.org_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    lo  = '{r.lo_x, r.lo_y, r.lo_z};
    hi  = '{r.hi_x, r.hi_y, r.hi_z};
    near_t = 0;
    far_t = TMax;
    live = 1'b1;
    for (int a = 0; a < 3 && live; a++) begin
      if (dir[a] == 0) begin
        // A ray parallel to the slab survives only from inside it.
        if (org[a] < lo[a] || org[a] > hi[a]) live = 1'b0;
        continue;
      end
      t0 = slab_distance(longint'(lo[a]) - longint'(org[a]), longint'(dir[a]));
      t1 = slab_distance(longint'(hi[a]) - longint'(org[a]), longint'(dir[a]));
      if (dir[a] < 0) begin
        swap = t0;
        t0 = t1;
        t1 = swap;
      end
      if (t0 > near_t) near_t = t0;
      if (t1 < far_t) far_t = t1;
      if (far_t <= near_t) live = 1'b0;
    end
    res = '0;
    if (live) begin
      res.hit = 1'b1;
      res.t_near = near_t[CW-2:0];
      res.t_far = far_t[CW-2:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // The driver presents the next ray on start, idling at random, and a ray is
  // taken when start is high and busy low at an edge. The prediction is queued at
  // that same edge, well before the result can appear.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_spans.push_back(clip_ray(ray_in));
        void'(pending_rays.pop_front());
      end
      // Decide the next cycle from the queue as it stands after this edge.
      if (pending_rays.size() > (start && !busy ? 0 : 0) &&
          !(start && !busy && pending_rays.size() == 0) &&
          ($urandom_range(99) >= send_idle_pct)) begin
        start <= 1'b1;
        ray_in <= pending_rays[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // The monitor takes each strobed result and checks it against the oldest
  // prediction; the receiver has no way to hold results off.
  always @(posedge clk) begin
    hit_span_t exp_span;
    if (rst_n && out_valid) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        exp_span = expected_spans.pop_front();
        if (out_hit !== exp_span.hit)
          report_mismatch($sformatf("hit %b, want %b", out_hit, exp_span.hit));
        if (out_t_near !== exp_span.t_near)
          report_mismatch($sformatf("t_near %h, want %h", out_t_near, exp_span.t_near));
        if (out_t_far !== exp_span.t_far)
          report_mismatch($sformatf("t_far %h, want %h", out_t_far, exp_span.t_far));
      end
    end
  end

  function automatic logic [CW-1:0] rand_word();
    return $urandom();
  endfunction

  // A coordinate of moderate size, so that boxes are actually hit.
  function automatic logic signed [CW-1:0] rand_coord();
    return $signed($urandom_range(40 << FB)) - (20 << FB);
  endfunction

  // A ray aimed from near the box toward it, with random sizes; the rest is
  // noise: full-range words, zero directions and inverted boxes.
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    int kind;
    kind = $urandom_range(99);
    if (kind < 15) begin
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      r.lo_x = rand_coord(); r.hi_x = r.lo_x + $urandom_range(8 << FB);
      r.lo_y = rand_coord(); r.hi_y = r.lo_y + $urandom_range(8 << FB);
      r.lo_z = rand_coord(); r.hi_z = r.lo_z + $urandom_range(8 << FB);
      r.org_x = rand_coord(); r.org_y = rand_coord(); r.org_z = rand_coord();
      // Pointing roughly at the box center gives many hits.
      r.dir_x = ((r.lo_x >>> 1) + (r.hi_x >>> 1) - r.org_x) >>> $urandom_range(6);
      r.dir_y = ((r.lo_y >>> 1) + (r.hi_y >>> 1) - r.org_y) >>> $urandom_range(6);
      r.dir_z = ((r.lo_z >>> 1) + (r.hi_z >>> 1) - r.org_z) >>> $urandom_range(6);
      if (kind < 30) r.dir_x = 0;
      else if (kind < 40) r.dir_y = 0;
      else if (kind < 50) r.dir_z = 0;
      else if (kind < 55) r.dir_y = rand_word();
      if (kind >= 90) {r.lo_x, r.hi_x} = {r.hi_x, r.lo_x};
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_rays.size() != 0 || start || expected_spans.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  localparam logic signed [CW-1:0] SMin = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] SMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] One  = 1 << FB;

  initial begin
    ray_box_t r;
    int idle_plan[4];
    idle_plan = '{0, 73, 0, 27};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays: unit box hits, misses, parallel cases, extremes.
    r = '{default: 0};
    r.org_x = -2 * One; r.dir_x = One;
    r.lo_x = -One; r.lo_y = -One; r.lo_z = -One;
    r.hi_x = One; r.hi_y = One; r.hi_z = One;
    pending_rays.push_back(r);                        // axis ray through the box
    r.org_y = 2 * One; pending_rays.push_back(r);     // parallel, outside in y
    r.org_y = One; pending_rays.push_back(r);         // parallel, on the upper face
    r.org_y = -One; pending_rays.push_back(r);        // parallel, on the lower face
    r.org_y = 0; r.dir_x = -One; pending_rays.push_back(r);  // pointing away
    r.org_x = 0; pending_rays.push_back(r);           // origin inside the box
    r.dir_x = 1; pending_rays.push_back(r);           // smallest step: saturates
    r.dir_x = SMin; pending_rays.push_back(r);
    r.dir_x = SMax; pending_rays.push_back(r);
    r.dir_y = One; r.dir_z = -One; r.org_x = 0; pending_rays.push_back(r);
    r.org_x = SMin; r.lo_x = SMax; r.hi_x = SMax; r.dir_x = 1;
    pending_rays.push_back(r);                        // widest difference
    r.org_x = SMax; r.lo_x = SMin; r.hi_x = SMin; r.dir_x = SMin;
    pending_rays.push_back(r);
    r = '{default: 0}; pending_rays.push_back(r);     // degenerate point box
    r = '{default: SMin}; pending_rays.push_back(r);
    r = '{default: SMax}; pending_rays.push_back(r);
    r = '{default: -1}; pending_rays.push_back(r);
    r = rand_ray(); {r.lo_x, r.hi_x} = {r.hi_x, r.lo_x};
    pending_rays.push_back(r);                        // inverted box
    wait_drained();

    // Random phases at the sender idle rates of the plan.
    foreach (idle_plan[p]) begin
      send_idle_pct = idle_plan[p];
      for (int i = 0; i < 220; i++) pending_rays.push_back(rand_ray());
      wait_drained();
    end
    // A stretch of full-range words so every input bit toggles.
    send_idle_pct = 0;
    for (int i = 0; i < 40; i++) begin
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      pending_rays.push_back(r);
    end
    wait_drained();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
